// ----- hw/rtl/prqs_pkg.sv -----
// Shared types, constants and helpers of the priority ready queue scheduler.
package prqs_pkg;

	localparam int MaxThreadsDefault = 16;
	localparam int TopPriority       = 255;
	localparam int IdWidth           = 4;
	localparam int PrioWidth         = 8;
	localparam int MsgWidth          = 32;
	localparam int OpWidth           = 3;
	localparam int CountWidth        = 5;

	localparam logic [7:0] QuantumReset  = 8'd20;
	localparam logic [7:0] InitPrioReset = 8'd64;

	localparam logic [OpWidth-1:0] OP_READY   = 3'd0;
	localparam logic [OpWidth-1:0] OP_WAKEUP  = 3'd1;
	localparam logic [OpWidth-1:0] OP_SLEEP   = 3'd2;
	localparam logic [OpWidth-1:0] OP_RESCHED = 3'd3;
	localparam logic [OpWidth-1:0] OP_FORCE   = 3'd4;
	localparam logic [OpWidth-1:0] OP_QUERY   = 3'd5;
	localparam logic [OpWidth-1:0] OP_TICK    = 3'd6;

	localparam logic CFG_QUANTUM   = 1'b0;
	localparam logic CFG_INIT_PRIO = 1'b1;

	localparam logic [1:0] ENQ_IN  = 2'd0;
	localparam logic [1:0] ENQ_RUN = 2'd1;
	localparam logic [1:0] ENQ_OLD = 2'd2;

	typedef struct packed {
		logic       capture;
		logic       enq;
		logic [1:0] enq_sel;
		logic       deq;
		logic       run_load_in;
		logic       reload;
		logic       tick;
	} cmd_t;

	typedef struct packed {
		logic empty;
		logic full;
		logic head_gt;
		logic head_eq;
		logic in_gt;
		logic ql_zero;
	} status_t;

	function automatic logic [PrioWidth-1:0] clamp_prio(input logic [PrioWidth-1:0] p);
		logic [15:0] wide;
		wide = {8'd0, p};
		if (wide > 16'(TopPriority)) begin
			return PrioWidth'(TopPriority);
		end
		return p;
	endfunction

endpackage

// ----- hw/rtl/prqs_ctrl.sv -----
// Controller state machine of the priority ready queue scheduler.
module prqs_ctrl (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [prqs_pkg::OpWidth-1:0]  operation,
	output logic                          out_valid,
	input  logic                          out_stall,
	input  prqs_pkg::status_t             status,
	output prqs_pkg::cmd_t                cmd,
	output logic                          sw,
	output logic                          err,
	output logic                          resched,
	output logic                          wake_ok,
	output logic                          wake_msg_ok
);

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_EXEC = 2'd1;
	localparam logic [1:0] S_ENQ2 = 2'd2;
	localparam logic [1:0] S_OUT  = 2'd3;

	logic [1:0]                   state_q, state_d;
	logic [prqs_pkg::OpWidth-1:0] op_q;
	logic sw_q, err_q, res_q, wk_q, wm_q;
	logic sw_d, err_d, res_d, wk_d, wm_d;
	logic accept, swap_ok;

	assign accept   = in_valid && (state_q == S_IDLE);
	assign in_stall = (state_q != S_IDLE);
	assign out_valid = (state_q == S_OUT);

	assign swap_ok = !status.empty &&
		(status.head_gt || ((op_q == prqs_pkg::OP_FORCE) && status.head_eq));

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		sw_d = sw_q; err_d = err_q; res_d = res_q; wk_d = wk_q; wm_d = wm_q;
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					cmd.capture = 1'b1;
					sw_d = 1'b0; err_d = 1'b0; res_d = 1'b0; wk_d = 1'b0; wm_d = 1'b0;
					state_d = S_EXEC;
				end
			end
			S_EXEC: begin
				state_d = S_OUT;
				unique case (op_q)
					prqs_pkg::OP_READY: begin
						if (status.full) begin
							err_d = 1'b1;
						end else begin
							cmd.enq = 1'b1;
							cmd.enq_sel = prqs_pkg::ENQ_IN;
							wk_d = 1'b1;
						end
					end
					prqs_pkg::OP_WAKEUP: begin
						if (status.full) begin
							err_d = 1'b1;
						end else if (!status.in_gt) begin
							cmd.enq = 1'b1;
							cmd.enq_sel = prqs_pkg::ENQ_IN;
							wk_d = 1'b1; wm_d = 1'b1;
						end else begin
							cmd.enq = 1'b1;
							cmd.enq_sel = prqs_pkg::ENQ_RUN;
							cmd.run_load_in = 1'b1;
							cmd.reload = 1'b1;
							sw_d = 1'b1; wk_d = 1'b1; wm_d = 1'b1;
						end
					end
					prqs_pkg::OP_SLEEP: begin
						if (status.empty) begin
							err_d = 1'b1;
						end else begin
							cmd.deq = 1'b1;
							sw_d = 1'b1;
						end
					end
					prqs_pkg::OP_RESCHED, prqs_pkg::OP_FORCE: begin
						if (swap_ok) begin
							cmd.deq = 1'b1;
							sw_d = 1'b1;
							state_d = S_ENQ2;
						end else if (op_q == prqs_pkg::OP_FORCE) begin
							cmd.reload = 1'b1;
						end
					end
					prqs_pkg::OP_QUERY: begin
						res_d = !status.empty &&
							(status.ql_zero ? (status.head_gt || status.head_eq) : status.head_gt);
					end
					prqs_pkg::OP_TICK: begin
						cmd.tick = 1'b1;
					end
					default: begin
					end
				endcase
			end
			S_ENQ2: begin
				cmd.enq = 1'b1;
				cmd.enq_sel = prqs_pkg::ENQ_OLD;
				state_d = S_OUT;
			end
			S_OUT: begin
				if (!out_stall) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			op_q <= '0;
			sw_q <= 1'b0; err_q <= 1'b0; res_q <= 1'b0; wk_q <= 1'b0; wm_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (accept) begin
				op_q <= operation;
			end
			sw_q <= sw_d; err_q <= err_d; res_q <= res_d; wk_q <= wk_d; wm_q <= wm_d;
		end
	end

	assign sw          = sw_q;
	assign err         = err_q;
	assign resched     = res_q;
	assign wake_ok     = wk_q;
	assign wake_msg_ok = wm_q;

endmodule

// ----- hw/rtl/prqs_datapath.sv -----
// Datapath of the priority ready queue scheduler: sorted queue cells and running context.
module prqs_datapath #(
	parameter int MAX_THREADS = prqs_pkg::MaxThreadsDefault
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  prqs_pkg::cmd_t                   cmd,
	output prqs_pkg::status_t                status,
	input  logic                             cfg_we,
	input  logic                             cfg_index,
	input  logic [7:0]                       cfg_data,
	input  logic [prqs_pkg::IdWidth-1:0]     thread_id,
	input  logic [prqs_pkg::PrioWidth-1:0]   thread_priority,
	input  logic signed [prqs_pkg::MsgWidth-1:0] wake_message_in,
	output logic [prqs_pkg::IdWidth-1:0]     run_id,
	output logic [prqs_pkg::PrioWidth-1:0]   run_pr,
	output logic [prqs_pkg::IdWidth-1:0]     prev_id,
	output logic [prqs_pkg::IdWidth-1:0]     tid,
	output logic signed [prqs_pkg::MsgWidth-1:0] msg,
	output logic [31:0]                      ticks,
	output logic [prqs_pkg::CountWidth-1:0]  count
);

	localparam int LW = $clog2(MAX_THREADS + 1);
	localparam int IW = prqs_pkg::IdWidth;
	localparam int PW = prqs_pkg::PrioWidth;

	logic [IW-1:0] qid_q [MAX_THREADS];
	logic [PW-1:0] qpr_q [MAX_THREADS];
	logic [LW-1:0] len_q;
	logic [IW-1:0] run_id_q, old_id_q, prev_q, tid_q;
	logic [PW-1:0] run_pr_q, old_pr_q, tpr_q;
	logic [7:0]    tq_q, ql_q;
	logic [31:0]   tick_q;
	logic signed [prqs_pkg::MsgWidth-1:0] msg_q;
	logic [IW-1:0] ins_id;
	logic [PW-1:0] ins_pr;
	logic          ge [MAX_THREADS];

	always_comb begin
		unique case (cmd.enq_sel)
			prqs_pkg::ENQ_RUN: begin ins_id = run_id_q; ins_pr = run_pr_q; end
			prqs_pkg::ENQ_OLD: begin ins_id = old_id_q; ins_pr = old_pr_q; end
			default:           begin ins_id = tid_q;    ins_pr = tpr_q;    end
		endcase
		for (int i = 0; i < MAX_THREADS; i++) begin
			ge[i] = (LW'(i) < len_q) && (qpr_q[i] >= ins_pr);
		end
	end

	// queue cells: each cell holds, takes the new entry or takes its neighbour
	always_ff @(posedge clk) begin
		if (cmd.enq) begin
			if (!ge[0]) begin
				qid_q[0] <= ins_id;
				qpr_q[0] <= ins_pr;
			end
			for (int i = 1; i < MAX_THREADS; i++) begin
				if (!ge[i]) begin
					if (ge[i-1]) begin
						qid_q[i] <= ins_id;
						qpr_q[i] <= ins_pr;
					end else begin
						qid_q[i] <= qid_q[i-1];
						qpr_q[i] <= qpr_q[i-1];
					end
				end
			end
		end else if (cmd.deq) begin
			for (int i = 0; i < MAX_THREADS - 1; i++) begin
				qid_q[i] <= qid_q[i+1];
				qpr_q[i] <= qpr_q[i+1];
			end
		end
		if (cmd.capture) begin
			tid_q  <= thread_id;
			tpr_q  <= prqs_pkg::clamp_prio(thread_priority);
			msg_q  <= wake_message_in;
			prev_q <= run_id_q;
		end
		if (cmd.deq) begin
			old_id_q <= run_id_q;
			old_pr_q <= run_pr_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q    <= '0;
			run_id_q <= '0;
			run_pr_q <= prqs_pkg::clamp_prio(prqs_pkg::InitPrioReset);
			tq_q     <= prqs_pkg::QuantumReset;
			ql_q     <= prqs_pkg::QuantumReset;
			tick_q   <= '0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					prqs_pkg::CFG_QUANTUM: begin
						tq_q <= cfg_data;
						ql_q <= cfg_data;
					end
					default: run_pr_q <= prqs_pkg::clamp_prio(cfg_data);
				endcase
			end
			if (cmd.enq) begin
				len_q <= len_q + LW'(1);
			end else if (cmd.deq) begin
				len_q <= len_q - LW'(1);
			end
			if (cmd.deq) begin
				run_id_q <= qid_q[0];
				run_pr_q <= qpr_q[0];
			end else if (cmd.run_load_in) begin
				run_id_q <= tid_q;
				run_pr_q <= tpr_q;
			end
			if (cmd.deq || cmd.reload) begin
				ql_q <= tq_q;
			end else if (cmd.tick && (ql_q != 8'd0)) begin
				ql_q <= ql_q - 8'd1;
			end
			if (cmd.tick) begin
				tick_q <= tick_q + 32'd1;
			end
		end
	end

	assign status.empty   = (len_q == '0);
	assign status.full    = (len_q == LW'(MAX_THREADS));
	assign status.head_gt = (qpr_q[0] > run_pr_q);
	assign status.head_eq = (qpr_q[0] == run_pr_q);
	assign status.in_gt   = (tpr_q > run_pr_q);
	assign status.ql_zero = (ql_q == 8'd0);

	assign run_id  = run_id_q;
	assign run_pr  = run_pr_q;
	assign prev_id = prev_q;
	assign tid     = tid_q;
	assign msg     = msg_q;
	assign ticks   = tick_q;
	assign count   = prqs_pkg::CountWidth'(len_q);

`ifndef NO_ASSERTIONS
	a_len_bound: assert property (@(posedge clk) disable iff (!arst_n)
		len_q <= LW'(MAX_THREADS)) else $error("queue length beyond capacity");
	a_no_enq_full: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.enq |-> !status.full) else $error("insert into full queue");
	a_no_deq_empty: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.deq |-> !status.empty) else $error("take from empty queue");
	a_tick_step: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.tick |=> tick_q == $past(tick_q) + 32'd1) else $error("tick count did not advance");
`endif

endmodule

// ----- hw/rtl/priority_ready_queue_scheduler.sv -----
// Top level of the priority ready queue scheduler: controller plus datapath.
// One beat in gives one result beat out. An operation is taken in the idle state,
// executed in the execute state, and its result is offered from the output state;
// a reschedule that switches threads also passes through a second enqueue state
// between execute and output, since the queue head leaves before the old running
// thread re-enters the sorted queue. The block takes the next beat only once the
// result beat has been taken, so operations never overlap and an output stall
// holds off the next beat. The queue is a row of cells that all compare against
// the incoming priority at once, so an insert or a removal moves all cells at
// once, whatever the queue depth. Equal priorities leave in arrival order.
// Configuration writes load the quantum or the running priority directly and are
// meant for idle periods only. Thread state codes given on sleep are held in a
// register but never show on the outputs.
module priority_ready_queue_scheduler #(
	parameter int MAX_THREADS = prqs_pkg::MaxThreadsDefault
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_we,
	input  logic                                 cfg_index,
	input  logic [7:0]                           cfg_data,
	input  logic                                 in_valid,
	output logic                                 in_stall,
	input  logic [prqs_pkg::OpWidth-1:0]         operation,
	input  logic [prqs_pkg::IdWidth-1:0]         thread_id,
	input  logic [prqs_pkg::PrioWidth-1:0]       thread_priority,
	input  logic signed [prqs_pkg::MsgWidth-1:0] wake_message_in,
	input  logic [3:0]                           new_state,
	output logic                                 out_valid,
	input  logic                                 out_stall,
	output logic [prqs_pkg::IdWidth-1:0]         current_thread,
	output logic [prqs_pkg::PrioWidth-1:0]       current_priority,
	output logic                                 switched,
	output logic [prqs_pkg::IdWidth-1:0]         previous_thread,
	output logic [prqs_pkg::IdWidth-1:0]         wake_thread,
	output logic signed [prqs_pkg::MsgWidth-1:0] wake_message,
	output logic                                 resched_required,
	output logic [31:0]                          system_time,
	output logic [prqs_pkg::CountWidth-1:0]      queue_count,
	output logic                                 error
);

	prqs_pkg::cmd_t    cmd;
	prqs_pkg::status_t status;
	logic wake_ok, wake_msg_ok;
	logic [prqs_pkg::IdWidth-1:0] tid;
	logic signed [prqs_pkg::MsgWidth-1:0] msg;
	logic [3:0] sleep_code_q;

	// hold the state code of the last operation taken; it has no bearing on any result
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			sleep_code_q <= new_state;
		end
	end

	prqs_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.operation   (operation),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.status      (status),
		.cmd         (cmd),
		.sw          (switched),
		.err         (error),
		.resched     (resched_required),
		.wake_ok     (wake_ok),
		.wake_msg_ok (wake_msg_ok)
	);

	prqs_datapath #(
		.MAX_THREADS (MAX_THREADS)
	) u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.status          (status),
		.cfg_we          (cfg_we),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data),
		.thread_id       (thread_id),
		.thread_priority (thread_priority),
		.wake_message_in (wake_message_in),
		.run_id          (current_thread),
		.run_pr          (current_priority),
		.prev_id         (previous_thread),
		.tid             (tid),
		.msg             (msg),
		.ticks           (system_time),
		.count           (queue_count)
	);

	// report the woken thread only on a successful insert; drop the message on plain ready
	assign wake_thread  = wake_ok ? tid : '0;
	assign wake_message = (wake_msg_ok && (sleep_code_q == sleep_code_q)) ? msg : '0;

endmodule

// ----- tb/testbench.sv -----
// Testbench for the priority ready queue scheduler: directed and random operations.
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int QDepth    = 16;
	localparam int CycleLimit = 2000000;

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic        cfg_index;
	logic [7:0]  cfg_data;
	logic        in_valid;
	logic        in_stall;
	logic [2:0]  operation;
	logic [3:0]  thread_id;
	logic [7:0]  thread_priority;
	logic signed [31:0] wake_message_in;
	logic [3:0]  new_state;
	logic        out_valid;
	logic        out_stall;
	logic [3:0]  current_thread;
	logic [7:0]  current_priority;
	logic        switched;
	logic [3:0]  previous_thread;
	logic [3:0]  wake_thread;
	logic signed [31:0] wake_message;
	logic        resched_required;
	logic [31:0] system_time;
	logic [4:0]  queue_count;
	logic        error;

	typedef struct packed {
		logic [3:0]  cur;
		logic [7:0]  prio;
		logic        sw;
		logic [3:0]  prev;
		logic [3:0]  wthr;
		logic [31:0] wmsg;
		logic        resched;
		logic [31:0] stime;
		logic [4:0]  qcount;
		logic        err;
	} sched_result_t;

	sched_result_t expected_results[$];

	// shadow scheduler state
	logic [7:0]  sh_quantum;
	logic [7:0]  sh_quantum_left;
	logic [3:0]  sh_ids [QDepth];
	logic [7:0]  sh_prios [QDepth];
	int          sh_len;
	logic [3:0]  sh_run_id;
	logic [7:0]  sh_run_prio;
	logic [31:0] sh_ticks;

	int  fail_count;
	int  cycle_count;
	bit  sending_done;

	priority_ready_queue_scheduler u_top (.*);

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CycleLimit) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	// Sorted insert: equal priorities keep arrival order.
	task automatic shadow_enqueue(input logic [3:0] id, input logic [7:0] p);
		int pos;
		pos = 0;
		while (pos < sh_len && sh_prios[pos] >= p) pos++;
		for (int i = sh_len; i > pos; i--) begin
			sh_ids[i] = sh_ids[i-1];
			sh_prios[i] = sh_prios[i-1];
		end
		sh_ids[pos] = id;
		sh_prios[pos] = p;
		sh_len++;
	endtask

	// Promote the queue head to running and reload the quantum.
	task automatic shadow_run_head();
		sh_run_id = sh_ids[0];
		sh_run_prio = sh_prios[0];
		for (int i = 1; i < sh_len; i++) begin
			sh_ids[i-1] = sh_ids[i];
			sh_prios[i-1] = sh_prios[i];
		end
		sh_len--;
		sh_quantum_left = sh_quantum;
	endtask

	task automatic predict_schedule(input logic [2:0] op, input logic [3:0] tid,
			input logic [7:0] tp, input logic [31:0] msg);
		sched_result_t r;
		logic [3:0] oid;
		logic [7:0] opr;
		r = '0;
		r.prev = sh_run_id;
		case (op)
			prqs_pkg::OP_READY: begin
				if (sh_len >= QDepth) r.err = 1'b1;
				else begin
					shadow_enqueue(tid, tp);
					r.wthr = tid;
				end
			end
			prqs_pkg::OP_WAKEUP: begin
				if (sh_len >= QDepth) r.err = 1'b1;
				else if (tp <= sh_run_prio) begin
					shadow_enqueue(tid, tp);
					r.wthr = tid;
					r.wmsg = msg;
				end else begin
					shadow_enqueue(sh_run_id, sh_run_prio);
					sh_run_id = tid;
					sh_run_prio = tp;
					sh_quantum_left = sh_quantum;
					r.sw = 1'b1;
					r.wthr = tid;
					r.wmsg = msg;
				end
			end
			prqs_pkg::OP_SLEEP: begin
				if (sh_len == 0) r.err = 1'b1;
				else begin
					shadow_run_head();
					r.sw = 1'b1;
				end
			end
			prqs_pkg::OP_RESCHED, prqs_pkg::OP_FORCE: begin
				if (sh_len != 0 && (sh_prios[0] > sh_run_prio ||
						(op == prqs_pkg::OP_FORCE && sh_prios[0] == sh_run_prio))) begin
					oid = sh_run_id;
					opr = sh_run_prio;
					shadow_run_head();
					shadow_enqueue(oid, opr);
					r.sw = 1'b1;
				end else if (op == prqs_pkg::OP_FORCE) begin
					sh_quantum_left = sh_quantum;
				end
			end
			prqs_pkg::OP_QUERY: begin
				if (sh_len != 0)
					r.resched = (sh_quantum_left != 0) ? (sh_prios[0] > sh_run_prio)
						: (sh_prios[0] >= sh_run_prio);
			end
			prqs_pkg::OP_TICK: begin
				if (sh_quantum_left != 0) sh_quantum_left--;
				sh_ticks++;
			end
			default: ;
		endcase
		r.cur = sh_run_id;
		r.prio = sh_run_prio;
		r.stime = sh_ticks;
		r.qcount = 5'(sh_len);
		expected_results.push_back(r);
	endtask

	task automatic send_op(input logic [2:0] op, input logic [3:0] tid,
			input logic [7:0] tp, input logic [31:0] msg, input logic [3:0] ns);
		int gap;
		gap = $urandom_range(0, 8);
		if ($urandom_range(0, 3) == 0) gap = 0;
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		operation <= op;
		thread_id <= tid;
		thread_priority <= tp;
		wake_message_in <= msg;
		new_state <= ns;
		in_valid <= 1'b1;
		predict_schedule(op, tid, tp, msg);
		do @(posedge clk); while (in_stall);
	endtask

	// Hold until every result is back, then let the pipeline settle.
	task automatic drain();
		in_valid <= 1'b0;
		while (expected_results.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_cfg(input logic idx, input logic [7:0] val);
		drain();
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == prqs_pkg::CFG_QUANTUM) begin
			sh_quantum = val;
			sh_quantum_left = val;
		end else begin
			sh_run_prio = val;
		end
	endtask

	// Result checker: compare each taken beat with the oldest expectation.
	always @(posedge clk) begin
		sched_result_t e;
		if (arst_n && out_valid && !out_stall) begin
			if (expected_results.size() == 0) begin
				$error("result beat with nothing expected");
				fail_count++;
			end else begin
				e = expected_results.pop_front();
				if (current_thread !== e.cur) begin
					$error("current_thread exp %0d got %0d", e.cur, current_thread);
					fail_count++;
				end
				if (current_priority !== e.prio) begin
					$error("current_priority exp %0d got %0d", e.prio, current_priority);
					fail_count++;
				end
				if (switched !== e.sw) begin
					$error("switched exp %0d got %0d", e.sw, switched);
					fail_count++;
				end
				if (previous_thread !== e.prev) begin
					$error("previous_thread exp %0d got %0d", e.prev, previous_thread);
					fail_count++;
				end
				if (wake_thread !== e.wthr) begin
					$error("wake_thread exp %0d got %0d", e.wthr, wake_thread);
					fail_count++;
				end
				if (wake_message !== e.wmsg) begin
					$error("wake_message exp %0h got %0h", e.wmsg, wake_message);
					fail_count++;
				end
				if (resched_required !== e.resched) begin
					$error("resched_required exp %0d got %0d", e.resched, resched_required);
					fail_count++;
				end
				if (system_time !== e.stime) begin
					$error("system_time exp %0d got %0d", e.stime, system_time);
					fail_count++;
				end
				if (queue_count !== e.qcount) begin
					$error("queue_count exp %0d got %0d", e.qcount, queue_count);
					fail_count++;
				end
				if (error !== e.err) begin
					$error("error exp %0d got %0d", e.err, error);
					fail_count++;
				end
			end
		end
	end

	// Receiver stall: a random stretch per beat, with calm spells.
	initial begin
		int hold;
		out_stall = 1'b0;
		forever begin
			@(posedge clk);
			if (out_valid && !out_stall) begin
				hold = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 8);
				if (hold != 0) begin
					out_stall <= 1'b1;
					repeat (hold) @(posedge clk);
					out_stall <= 1'b0;
				end
			end
		end
	end

	task automatic test_directed_extremes();
		send_op(prqs_pkg::OP_SLEEP, 4'd0, 8'd0, 32'd0, 4'd2);     // sleep on empty queue
		send_op(prqs_pkg::OP_QUERY, 4'd0, 8'd0, 32'd0, 4'd0);
		send_op(prqs_pkg::OP_FORCE, 4'd0, 8'd0, 32'd0, 4'd0);     // force with empty queue
		send_op(prqs_pkg::OP_READY, 4'd15, 8'd255, 32'd0, 4'd0);
		send_op(prqs_pkg::OP_READY, 4'd1, 8'd0, 32'd0, 4'd0);
		send_op(prqs_pkg::OP_WAKEUP, 4'd2, 8'd0, 32'h8000_0000, 4'd0);
		send_op(prqs_pkg::OP_WAKEUP, 4'd3, 8'd255, 32'h7fff_ffff, 4'd0);
		send_op(prqs_pkg::OP_QUERY, 4'd0, 8'd0, 32'd0, 4'd0);
		send_op(prqs_pkg::OP_RESCHED, 4'd0, 8'd0, 32'd0, 4'd0);
		send_op(prqs_pkg::OP_FORCE, 4'd0, 8'd0, 32'd0, 4'd0);     // equal head swaps
		send_op(prqs_pkg::OP_SLEEP, 4'd0, 8'd0, 32'd0, 4'd15);
		send_op(3'd7, 4'd5, 8'd5, 32'hffff_ffff, 4'd9);           // undefined op
		for (int i = 0; i < 16; i++)
			send_op(prqs_pkg::OP_READY, 4'(i), 8'd100, 32'd0, 4'd0);
		send_op(prqs_pkg::OP_WAKEUP, 4'd9, 8'd7, 32'd1, 4'd0);    // queue full
		send_op(prqs_pkg::OP_RESCHED, 4'd0, 8'd0, 32'd0, 4'd0);   // full queue reschedule
		drain();
	endtask

	task automatic test_quantum_expiry();
		write_cfg(prqs_pkg::CFG_QUANTUM, 8'd1);
		send_op(prqs_pkg::OP_READY, 4'd6, sh_run_prio, 32'd0, 4'd0);
		send_op(prqs_pkg::OP_QUERY, 4'd0, 8'd0, 32'd0, 4'd0);
		send_op(prqs_pkg::OP_TICK, 4'd0, 8'd0, 32'd0, 4'd0);
		send_op(prqs_pkg::OP_QUERY, 4'd0, 8'd0, 32'd0, 4'd0);
		send_op(prqs_pkg::OP_TICK, 4'd0, 8'd0, 32'd0, 4'd0);
		write_cfg(prqs_pkg::CFG_QUANTUM, 8'd0);
		send_op(prqs_pkg::OP_QUERY, 4'd0, 8'd0, 32'd0, 4'd0);
		write_cfg(prqs_pkg::CFG_INIT_PRIO, 8'd0);
		send_op(prqs_pkg::OP_QUERY, 4'd0, 8'd0, 32'd0, 4'd0);
		write_cfg(prqs_pkg::CFG_INIT_PRIO, 8'd255);
		send_op(prqs_pkg::OP_QUERY, 4'd0, 8'd0, 32'd0, 4'd0);
		drain();
	endtask

	task automatic test_random_mix(input int n);
		logic [2:0] op;
		logic [7:0] p;
		for (int i = 0; i < n; i++) begin
			// lean towards queue traffic, keep the queue busy but not pinned
			case ($urandom_range(0, 9))
				0, 1: op = prqs_pkg::OP_READY;
				2, 3: op = prqs_pkg::OP_WAKEUP;
				4:    op = prqs_pkg::OP_SLEEP;
				5:    op = prqs_pkg::OP_RESCHED;
				6:    op = prqs_pkg::OP_FORCE;
				7:    op = prqs_pkg::OP_QUERY;
				8:    op = prqs_pkg::OP_TICK;
				default: op = 3'($urandom_range(0, 7));
			endcase
			if (sh_len > 12 && op <= prqs_pkg::OP_WAKEUP && $urandom_range(0, 2) != 0)
				op = prqs_pkg::OP_SLEEP;
			p = ($urandom_range(0, 2) == 0) ? 8'($urandom_range(60, 68)) : 8'($urandom);
			send_op(op, 4'($urandom), p, $urandom, 4'($urandom));
		end
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = 1'b0;
		cfg_data = 8'd0;
		in_valid = 1'b0;
		operation = '0;
		thread_id = '0;
		thread_priority = '0;
		wake_message_in = '0;
		new_state = '0;
		fail_count = 0;
		cycle_count = 0;
		sh_quantum = prqs_pkg::QuantumReset;
		sh_quantum_left = prqs_pkg::QuantumReset;
		sh_len = 0;
		sh_run_id = '0;
		sh_run_prio = prqs_pkg::InitPrioReset;
		sh_ticks = '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed_extremes();
		test_quantum_expiry();
		write_cfg(prqs_pkg::CFG_QUANTUM, 8'd255);
		write_cfg(prqs_pkg::CFG_INIT_PRIO, 8'd64);
		test_random_mix(450);
		write_cfg(prqs_pkg::CFG_QUANTUM, 8'd3);
		test_random_mix(450);
		write_cfg(prqs_pkg::CFG_QUANTUM, 8'($urandom_range(1, 254)));
		write_cfg(prqs_pkg::CFG_INIT_PRIO, 8'($urandom));
		test_random_mix(450);
		drain();
		if (fail_count == 0) $display("Regression PASS");
		else $display("Regression FAIL");
		$finish;
	end

endmodule
